// File: sv/cpfsk_pkg.sv
// Package: widths, register indexes, command type and the quarter-wave sine table.
package cpfsk_pkg;

    localparam int PHASE_BITS  = 16;
    localparam int TABLE_BITS  = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SPS     = 64;

    localparam int SYMBOL_BITS = 8;
    localparam int SPS_CFG_BITS = 7;
    localparam int STEP_BITS   = 16;
    localparam int SPS_BITS    = $clog2(MAX_SPS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STEP = 2'd1;

    localparam logic [SPS_CFG_BITS-1:0] SPS_RESET  = 7'd8;
    localparam logic [STEP_BITS-1:0]    STEP_RESET = 16'd4096;

    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int MAG_BITS = SAMPLE_BITS - 1;

    // Taylor series constants, Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned SCALE_DEN   = 64'd1000 << (31 - SAMPLE_BITS);
    localparam longint unsigned TAYLOR_DIV [1:12] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

    typedef logic [PHASE_BITS-1:0]          t_phase;
    typedef logic [TABLE_BITS-1:0]          t_tidx;
    typedef logic [SPS_BITS-1:0]            t_sps;
    typedef logic signed [SAMPLE_BITS-1:0]  t_sample;
    typedef logic [MAG_BITS-1:0]            t_mag;
    typedef t_mag t_mag_rom [QUARTER];

    // One classified symbol: direction and sample count
    typedef struct packed {
        logic up;
        t_sps sps;
    } t_cmd;

    // |sin| scaled by 0.999 to the sample format, r in 0..QUARTER
    function automatic t_mag scaled_sine(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint signed   sum;
        longint unsigned v;
        x    = (64'(r) * HALF_PI_Q30 + 64'(QUARTER / 2)) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        v = longint'(sum) * 64'd999;
        return MAG_BITS'((v + SCALE_DEN / 2) / SCALE_DEN);
    endfunction

    function automatic t_mag_rom build_mag_rom();
        t_mag_rom rom;
        for (int k = 0; k < QUARTER; k++) begin
            rom[k] = scaled_sine(k);
        end
        return rom;
    endfunction

    localparam t_mag_rom MAG_ROM  = build_mag_rom();
    localparam t_mag     MAG_PEAK = scaled_sine(QUARTER);

    // Top table bits of the phase; left shift when the phase is narrower
    function automatic t_tidx phase_to_index(input t_phase phase);
        logic [PHASE_BITS+TABLE_BITS-1:0] w;
        w = {phase, {TABLE_BITS{1'b0}}};
        return w[PHASE_BITS+TABLE_BITS-1 -: TABLE_BITS];
    endfunction

    // Full-wave sine from the quarter-wave magnitudes
    function automatic t_sample sine_lookup(input t_tidx idx);
        logic [1:0]            quad;
        logic [TABLE_BITS-3:0] r;
        logic [TABLE_BITS-2:0] a;
        t_mag                  mag;
        t_sample               s;
        quad = idx[TABLE_BITS-1 -: 2];
        r    = idx[TABLE_BITS-3:0];
        a    = quad[0] ? ((TABLE_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        mag  = a[TABLE_BITS-2] ? MAG_PEAK : MAG_ROM[a[TABLE_BITS-3:0]];
        s    = $signed({1'b0, mag});
        return quad[1] ? -s : s;
    endfunction

endpackage

// File: sv/cpfsk_if.sv
// Interfaces: symbol stream, sample stream and configuration write channel.
interface cpfsk_sym_if import cpfsk_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SYMBOL_BITS-1:0] symbol;
    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface cpfsk_smp_if import cpfsk_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample i_sample;
    t_sample q_sample;
    logic    last_of_symbol;
    modport source (output valid, output i_sample, output q_sample,
                    output last_of_symbol, input ready);
    modport sink   (input valid, input i_sample, input q_sample,
                    input last_of_symbol, output ready);
endinterface

interface cpfsk_cfg_if import cpfsk_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/cpfsk_front.sv
// Front end: accepts symbols, classifies them and queues commands for the generator.
module cpfsk_front import cpfsk_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    cpfsk_sym_if.sink               i_sym,
    input  logic [SPS_CFG_BITS-1:0] i_sps,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  logic                    i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       n_cmd;
    logic       push;
    logic       pop;

    // Classify: direction and clamped sample count
    always_comb begin
        n_cmd.up = (i_sym.symbol == SYMBOL_BITS'(1));
        if (i_sps == '0) begin
            n_cmd.sps = SPS_BITS'(1);
        end else if (i_sps > SPS_CFG_BITS'(MAX_SPS)) begin
            n_cmd.sps = SPS_BITS'(MAX_SPS);
        end else begin
            n_cmd.sps = SPS_BITS'(i_sps);
        end
    end

    assign i_sym.ready = (r_count != 2'd2);
    assign push        = i_sym.valid && i_sym.ready;
    assign pop         = i_cmd_pop && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("command queue count out of range");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_count != 2'd0)
        else $error("queue empty after a transfer in");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !pop) |=> r_count == 2'd2)
        else $error("full queue lost an entry without a pop");
`endif

endmodule

// File: sv/cpfsk_back.sv
// Back end: steps the phase accumulator per sample and looks up cos/sin into the output register.
module cpfsk_back import cpfsk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_cmd_pop,
    input  logic [STEP_BITS-1:0] i_step,
    cpfsk_smp_if.source          o_smp
);

    // Current symbol
    logic    r_busy;
    logic    r_up;
    t_sps    r_left;
    // Phase stage
    logic    r_gen_valid;
    logic    r_gen_last;
    t_phase  r_phase;
    t_phase  n_phase;
    // Output stage
    logic    r_out_valid;
    t_sample r_i;
    t_sample r_q;
    logic    r_last;

    logic    out_load;
    logic    gen_adv;
    logic    gen_fire;
    logic    is_last;
    logic    load;
    t_tidx   sin_idx;
    t_tidx   cos_idx;

    assign out_load = !r_out_valid || o_smp.ready;
    assign gen_adv  = !r_gen_valid || out_load;
    assign gen_fire = r_busy && gen_adv;
    assign is_last  = (r_left == SPS_BITS'(1));
    assign load     = i_cmd_valid && (!r_busy || (gen_fire && is_last));
    assign o_cmd_pop = load;

    assign n_phase = r_up ? (r_phase + PHASE_BITS'(i_step))
                          : (r_phase - PHASE_BITS'(i_step));

    // Symbol sequencer: counts down the samples of one symbol
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_up   <= 1'b0;
            r_left <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_up   <= i_cmd.up;
            r_left <= i_cmd.sps;
        end else if (gen_fire) begin
            r_left <= r_left - SPS_BITS'(1);
            if (is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Phase accumulator stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_valid <= 1'b0;
            r_gen_last  <= 1'b0;
            r_phase     <= '0;
        end else if (gen_adv) begin
            r_gen_valid <= gen_fire;
            if (gen_fire) begin
                r_phase    <= n_phase;
                r_gen_last <= is_last;
            end
        end
    end

    // Table lookup into the output register
    assign sin_idx = phase_to_index(r_phase);
    assign cos_idx = sin_idx + TABLE_BITS'(QUARTER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_gen_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_gen_valid) begin
            r_i    <= sine_lookup(cos_idx);
            r_q    <= sine_lookup(sin_idx);
            r_last <= r_gen_last;
        end
    end

    assign o_smp.valid          = r_out_valid;
    assign o_smp.i_sample       = r_i;
    assign o_smp.q_sample       = r_q;
    assign o_smp.last_of_symbol = r_last;

`ifndef NO_ASSERTIONS
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0 && r_left <= SPS_BITS'(MAX_SPS)))
        else $error("sample count out of range while busy");
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_fire |=> (r_gen_valid && r_gen_last == ($past(r_left) == SPS_BITS'(1))))
        else $error("last flag does not match the sample count");
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen_fire && r_up) |=> r_phase == $past(r_phase + PHASE_BITS'(i_step)))
        else $error("phase did not advance by the step");
`endif

endmodule

// File: sv/cpfsk_modulator.sv
// Top level: configuration registers, symbol front end and sample generator.
// Continuous-phase FSK modulator.
// Channels: i_sym takes one symbol byte per transfer; o_smp gives one
// (i_sample, q_sample, last_of_symbol) sample per transfer; i_cfg writes
// register 0 (samples per symbol) or 1 (angle step); other indexes are
// ignored. i_cfg is always ready; write it only while the block is idle.
// Each symbol gives as many samples as register 0 holds (0 counts as 1,
// above 64 as 64). Symbol 1 moves the phase up by angle_step each sample,
// any other value moves it down; the phase moves before each lookup.
// Throughput: one sample per cycle while the receiver is ready, set by the
// single phase accumulator in the back end. A symbol's first sample passes
// the command queue, symbol sequencer, phase stage and output register.
// A two-entry command queue lets symbols be taken while samples wait.
// Reset: phase 0, 8 samples per symbol, angle_step 4096, command queue empty.
// When the receiver stalls, the output register holds its sample, the
// generator stops, and the queue fills until i_sym.ready drops.
module cpfsk_modulator import cpfsk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cpfsk_sym_if.sink    i_sym,
    cpfsk_cfg_if.sink    i_cfg,
    cpfsk_smp_if.source  o_smp
);

    logic [SPS_CFG_BITS-1:0] r_sps;
    logic [STEP_BITS-1:0]    r_step;
    logic                    cmd_valid;
    t_cmd                    cmd;
    logic                    cmd_pop;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps  <= SPS_RESET;
            r_step <= STEP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == CFG_IDX_SPS) begin
                r_sps <= i_cfg.data[SPS_CFG_BITS-1:0];
            end else if (i_cfg.index == CFG_IDX_STEP) begin
                r_step <= i_cfg.data[STEP_BITS-1:0];
            end
        end
    end

    cpfsk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym       (i_sym),
        .i_sps       (r_sps),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    cpfsk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_step      (r_step),
        .o_smp       (o_smp)
    );

endmodule

// File: tb/cpfsk_sample_checker.sv
// Checker: predicts the sample stream from observed transfers and compares each sample.
`timescale 1ns / 100ps
module cpfsk_sample_checker import cpfsk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cpfsk_sym_if sym,
    cpfsk_cfg_if cfg,
    cpfsk_smp_if smp,
    output int   o_errors,
    output int   o_pending,
    output int   o_samples
);

    localparam int              TB_TABLE_SIZE = 1 << TABLE_BITS;
    localparam int              TB_QUARTER    = 1 << (TABLE_BITS - 2);
    localparam longint unsigned PI_HALF_Q30   = 64'd1686629713;
    localparam longint unsigned UNIT_Q30      = 64'd1 << 30;

    typedef struct packed {
        t_sample i_sample;
        t_sample q_sample;
        logic    last;
    } t_iq_sample;

    t_sample                 sine_rom [TB_TABLE_SIZE];
    t_iq_sample              expected_samples [$];
    logic [SPS_CFG_BITS-1:0] sps_reg;
    logic [STEP_BITS-1:0]    step_reg;
    t_phase                  carrier_phase;
    int                      error_count  = 0;
    int                      sample_count = 0;

    // |sin(r * pi/2 / quarter)| in Q30 from a 13-term Taylor series
    function automatic longint unsigned sine_mag_q30(input int r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint signed   acc;
        x    = (64'(r) * PI_HALF_Q30 + 64'(TB_QUARTER / 2)) / 64'(TB_QUARTER);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(UNIT_Q30)) begin
            acc = longint'(UNIT_Q30);
        end
        return longint'(acc);
    endfunction

    // 0.999 scaling to the sample format, rounded half up on the magnitude
    function automatic int scaled_mag(input int r);
        longint unsigned v;
        longint unsigned den;
        v   = sine_mag_q30(r) * 64'd999;
        den = 64'd1000 << (31 - SAMPLE_BITS);
        return int'((v + den / 2) / den);
    endfunction

    // Full-wave table mirrored from one quarter
    initial begin
        int quad;
        int r;
        int m;
        for (int k = 0; k < TB_TABLE_SIZE; k++) begin
            quad = (k >> (TABLE_BITS - 2)) & 3;
            r    = k & (TB_QUARTER - 1);
            m    = (quad & 1) ? scaled_mag(TB_QUARTER - r) : scaled_mag(r);
            sine_rom[k] = (quad & 2) ? t_sample'(-m) : t_sample'(m);
        end
    end

    // Expected samples for one symbol; advances the carrier phase
    task automatic predict_symbol_samples(input logic [SYMBOL_BITS-1:0] code);
        int         count;
        logic       rising;
        t_tidx      idx;
        t_iq_sample smp_exp;
        count  = (sps_reg == '0) ? 1 : ((sps_reg > MAX_SPS) ? MAX_SPS : int'(sps_reg));
        rising = (code == SYMBOL_BITS'(1));
        for (int j = 0; j < count; j++) begin
            carrier_phase = rising ? carrier_phase + step_reg : carrier_phase - step_reg;
            idx = t_tidx'({carrier_phase, {TABLE_BITS{1'b0}}} >> PHASE_BITS);
            smp_exp.q_sample = sine_rom[idx];
            smp_exp.i_sample = sine_rom[t_tidx'(idx + TB_QUARTER)];
            smp_exp.last     = (j == count - 1);
            expected_samples.push_back(smp_exp);
        end
    endtask

    // Watch all three channels at each edge
    always @(posedge i_clk) begin
        t_iq_sample want;
        if (!i_rst_n) begin
            sps_reg       = SPS_RESET;
            step_reg      = STEP_RESET;
            carrier_phase = '0;
            expected_samples.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_IDX_SPS:  sps_reg  = cfg.data[SPS_CFG_BITS-1:0];
                    CFG_IDX_STEP: step_reg = cfg.data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (sym.valid && sym.ready) begin
                predict_symbol_samples(sym.symbol);
            end
            if (smp.valid && smp.ready) begin
                sample_count++;
                if (expected_samples.size() == 0) begin
                    $error("unexpected sample transfer: i_sample %0d q_sample %0d last %0b",
                           smp.i_sample, smp.q_sample, smp.last_of_symbol);
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (smp.i_sample !== want.i_sample) begin
                        $error("i_sample: expected %0d, actual %0d",
                               want.i_sample, smp.i_sample);
                        error_count++;
                    end
                    if (smp.q_sample !== want.q_sample) begin
                        $error("q_sample: expected %0d, actual %0d",
                               want.q_sample, smp.q_sample);
                        error_count++;
                    end
                    if (smp.last_of_symbol !== want.last) begin
                        $error("last_of_symbol: expected %0b, actual %0b",
                               want.last, smp.last_of_symbol);
                        error_count++;
                    end
                end
            end
        end
        o_errors  <= error_count;
        o_pending <= expected_samples.size();
        o_samples <= sample_count;
    end

endmodule

// File: tb/tb_cpfsk_modulator.sv
// Testbench top: clock, reset, symbol and config stimulus, output throttling and verdict.
`timescale 1ns / 100ps
module tb_cpfsk_modulator;
    import cpfsk_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int STALL_LIMIT    = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_SYMBOLS = 90;
    localparam int IDLE_RARE      = 14;
    localparam int IDLE_OFTEN     = 87;

    localparam logic [SYMBOL_BITS-1:0]  SYM_UP           = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED_B = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   tx_idle_pct = IDLE_RARE;
    int   rx_idle_pct = IDLE_OFTEN;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_left   = 0;
    int   quiet_cycles = 0;

    int   symbols_sent   = 0;
    int   settings_count = 0;
    int   errors;
    int   pending;
    int   samples_seen;

    cpfsk_sym_if sym_if ();
    cpfsk_cfg_if cfg_if ();
    cpfsk_smp_if smp_if ();

    cpfsk_modulator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sym   (sym_if),
        .i_cfg   (cfg_if),
        .o_smp   (smp_if)
    );

    cpfsk_sample_checker checker_inst (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .sym       (sym_if),
        .cfg       (cfg_if),
        .smp       (smp_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_samples (samples_seen)
    );

    always #1 clk = ~clk;

    // Sample receiver: random ready, plus one long hold-off on request
    initial begin
        smp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                smp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                smp_if.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                smp_if.ready <= 1'b0;
                hold_left    <= LONG_HOLD;
                hold_done    <= 1'b1;
            end else begin
                smp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk) begin
        if (!rst_n || (sym_if.valid && sym_if.ready) || (smp_if.valid && smp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d samples outstanding",
                     quiet_cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // One symbol transfer; valid stays high afterwards
    task automatic send_symbol(input logic [SYMBOL_BITS-1:0] code);
        while ($urandom_range(99) < tx_idle_pct) begin
            sym_if.valid <= 1'b0;
            @(posedge clk);
        end
        sym_if.valid  <= 1'b1;
        sym_if.symbol <= code;
        @(posedge clk);
        while (!sym_if.ready) begin
            @(posedge clk);
        end
        symbols_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) begin
            @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering symbols and wait for every expected sample
    task automatic wait_drained();
        sym_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] sps_data,
                                 input logic [CFG_DATA_BITS-1:0] step_data);
        wait_drained();
        write_reg(CFG_IDX_SPS, sps_data);
        write_reg(CFG_IDX_STEP, step_data);
        settings_count++;
    endtask

    // Main stimulus
    initial begin
        logic [CFG_DATA_BITS-1:0] sps_data;
        logic [CFG_DATA_BITS-1:0] step_data;
        int                       block_len;
        int                       sps_val;
        int                       random_sent;
        int                       directed_sent;
        logic                     stall_block;
        logic                     stall_asked;
        sym_if.valid  <= 1'b0;
        sym_if.symbol <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        random_sent = 0;
        stall_asked = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: up and down, byte extremes, phase wrap both ways
        send_symbol(SYM_UP);
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_symbol(8'h00);
        send_symbol(SYM_UP);
        send_symbol(SYM_UP);
        send_symbol(8'h80);
        send_symbol(8'h7F);
        send_symbol(8'h02);

        // Zero samples per symbol acts as one; largest step
        apply_setting(16'h0000, 16'hFFFF);
        send_symbol(SYM_UP);
        send_symbol(8'hFE);
        send_symbol(SYM_UP);

        // Oversized count saturates; zero step holds the phase
        apply_setting(16'h007F, 16'h0000);
        send_symbol(8'h55);
        send_symbol(SYM_UP);

        // Writes to unused indexes change nothing; upper data bits are dropped
        wait_drained();
        write_reg(CFG_IDX_UNUSED_A, 16'hFFFF);
        write_reg(CFG_IDX_UNUSED_B, 16'h0001);
        apply_setting(16'hFF81, 16'h8000);
        send_symbol(SYM_UP);
        send_symbol(SYM_UP);
        send_symbol(8'hAA);

        // Largest legal count with its nominal step
        apply_setting(16'd64, 16'd512);
        send_symbol(SYM_UP);
        send_symbol(8'h00);
        directed_sent = symbols_sent;

        // Random blocks, each under a fresh register setting
        while (random_sent < RANDOM_SYMBOLS) begin
            stall_block = 1'b0;
            if (random_sent >= 2 * RANDOM_SYMBOLS / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end else if (random_sent >= RANDOM_SYMBOLS / 3) begin
                tx_idle_pct <= IDLE_OFTEN;
                rx_idle_pct <= IDLE_RARE;
            end
            if (random_sent >= 2 * RANDOM_SYMBOLS / 3 && !stall_asked) begin
                // long output hold-off while symbols keep coming
                sps_data    = 16'd16;
                step_data   = 16'd2048;
                block_len   = 12;
                stall_asked = 1'b1;
                stall_block = 1'b1;
            end else begin
                case ($urandom_range(9))
                    0: begin
                        sps_data  = {9'($urandom), 7'd64};
                        step_data = 16'd512;
                        block_len = 2;
                    end
                    1: begin
                        sps_data  = {9'($urandom), 7'd0};
                        step_data = 16'($urandom);
                        block_len = 6;
                    end
                    2: begin
                        sps_data  = {9'($urandom), 7'($urandom_range(127, 65))};
                        step_data = 16'($urandom);
                        block_len = 1;
                    end
                    default: begin
                        sps_val   = 1 << $urandom_range(4);
                        sps_data  = {9'($urandom), 7'(sps_val)};
                        step_data = ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'(32768 / sps_val);
                        block_len = $urandom_range(12, 4);
                    end
                endcase
            end
            apply_setting(sps_data, step_data);
            if (stall_block) begin
                hold_req <= 1'b1;
            end
            repeat (block_len) begin
                send_symbol(($urandom_range(1) == 1) ? SYM_UP : 8'($urandom));
                random_sent++;
            end
        end

        // Drain, then let any stray samples show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d symbols (%0d directed) under %0d register settings, %0d samples",
                 symbols_sent, directed_sent, settings_count, samples_seen);
        $display("Throttled each side in turn, ran unthrottled, held the output %0d cycles",
                 LONG_HOLD);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
